@@ rtl/ctok_pkg.sv @@
// Shared types, token kind codes, keyword table and byte class functions
// for the C subset tokenizer. No dependencies.
`default_nettype none

package ctok_pkg;

  // Field widths of the token stream
  localparam int CH_W    = 8;
  localparam int KIND_W  = 6;
  localparam int START_W = 24;
  localparam int LEN_W   = 8;

  // Parameter defaults for the top level
  localparam int POS_WIDTH_DEF = 24;
  localparam int MAX_KW_DEF    = 11;

  // Scanner modes (state codes)
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NUM   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_IDENT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OP    = 2'd3;

  // Token kinds
  localparam logic [KIND_W-1:0] K_END     = 6'd0;
  localparam logic [KIND_W-1:0] K_NUMBER  = 6'd10;
  localparam logic [KIND_W-1:0] K_IDENT   = 6'd11;
  localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd12;
  localparam logic [KIND_W-1:0] K_PLUS    = 6'd14;
  localparam logic [KIND_W-1:0] K_MINUS   = 6'd15;
  localparam logic [KIND_W-1:0] K_STAR    = 6'd16;
  localparam logic [KIND_W-1:0] K_SLASH   = 6'd17;
  localparam logic [KIND_W-1:0] K_PERCENT = 6'd18;
  localparam logic [KIND_W-1:0] K_LT      = 6'd19;
  localparam logic [KIND_W-1:0] K_GT      = 6'd21;
  localparam logic [KIND_W-1:0] K_AND     = 6'd23;
  localparam logic [KIND_W-1:0] K_OR      = 6'd25;
  localparam logic [KIND_W-1:0] K_NOT     = 6'd27;
  localparam logic [KIND_W-1:0] K_XOR     = 6'd29;
  localparam logic [KIND_W-1:0] K_LPAREN  = 6'd30;
  localparam logic [KIND_W-1:0] K_RPAREN  = 6'd31;
  localparam logic [KIND_W-1:0] K_SEMI    = 6'd32;
  localparam logic [KIND_W-1:0] K_LBRACE  = 6'd33;
  localparam logic [KIND_W-1:0] K_RBRACE  = 6'd34;
  localparam logic [KIND_W-1:0] K_COMMA   = 6'd35;
  localparam logic [KIND_W-1:0] K_INVALID = 6'd36;

  // Keyword table; kind of keyword i is i+1.
  // Text is stored byte-reversed so character j sits at bits [8*j +: 8].
  localparam int KW_COUNT  = 9;
  localparam int KW_MAXLEN = 11;
  localparam int KW_LEN_W  = 4;
  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_COUNT] = '{
    88'("tni"), 88'("tni_nltnirp"), 88'("nruter"), 88'("diov"), 88'("fi"),
    88'("esle"), 88'("elihw"), 88'("eunitnoc"), 88'("kaerb")
  };
  localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd11, 4'd6, 4'd4, 4'd2, 4'd4, 4'd5, 4'd8, 4'd5
  };

  // Output queue geometry
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = 3;
  localparam int OQ_CW    = 4;

  // One token
  typedef struct packed {
    logic               last;
    logic [LEN_W-1:0]   len;
    logic [START_W-1:0] start;
    logic [KIND_W-1:0]  kind;
  } tok_t;

  // Up to two tokens produced by one byte, in order t0 then t1
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t1;
    tok_t       t0;
  } tok_pair_t;

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [CH_W-1:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic is_ident(input logic [CH_W-1:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_");
  endfunction

  // Characters that may pair with the following byte
  function automatic logic holds(input logic [CH_W-1:0] c);
    return c inside {"=", "<", ">", "&", "|", "!"};
  endfunction

  function automatic logic [CH_W-1:0] second_of(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] r;
    case (c)
      "&":     r = "&";
      "|":     r = "|";
      default: r = "=";
    endcase
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] single_op_kind(input logic [CH_W-1:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      "=":     k = K_ASSIGN;
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      "/":     k = K_SLASH;
      "%":     k = K_PERCENT;
      "<":     k = K_LT;
      ">":     k = K_GT;
      "&":     k = K_AND;
      "|":     k = K_OR;
      "!":     k = K_NOT;
      "^":     k = K_XOR;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      ";":     k = K_SEMI;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      ",":     k = K_COMMA;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ctok_lex.sv @@
// Scanner core: input byte register, scanner state, keyword buffer and the
// per-byte token decision. Depends on ctok_pkg.
`default_nettype none

module ctok_lex #(
  parameter int POS_WIDTH       = ctok_pkg::POS_WIDTH_DEF,
  parameter int MAX_KEYWORD_LEN = ctok_pkg::MAX_KW_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      take,     // byte transfer on the input side
  input  wire logic [ctok_pkg::CH_W-1:0] take_ch,
  input  wire logic                      take_end,
  output logic                           busy,     // a byte sits in the input register
  output ctok_pkg::tok_pair_t            wr        // tokens for the output queue
);

  localparam int KB_AW = $clog2(MAX_KEYWORD_LEN);

  // Input register
  logic                      stage_v;
  logic [ctok_pkg::CH_W-1:0] stage_ch;
  logic                      stage_end;

  // Scanner state
  logic [ctok_pkg::MODE_W-1:0]  mode, mode_next;
  logic [ctok_pkg::CH_W-1:0]    pending_op, pending_op_next;
  logic [ctok_pkg::START_W-1:0] token_start, token_start_next;
  logic [ctok_pkg::LEN_W-1:0]   token_length, token_length_next;
  logic [POS_WIDTH-1:0]         byte_position, byte_position_next;
  logic [ctok_pkg::CH_W-1:0]    keyword_buffer [MAX_KEYWORD_LEN];

  logic                      kb_we;
  logic [KB_AW-1:0]          kb_idx;

  logic [31:0]                  pos_ext;
  logic [ctok_pkg::START_W-1:0] pos_lo;
  logic [ctok_pkg::KIND_W-1:0]  kw_kind;

  ctok_pkg::tok_t flush_tok, new_tok;
  logic           flush_v, new_v;
  logic           cont, pair;

  assign busy    = stage_v;
  assign pos_ext = 32'(byte_position);
  assign pos_lo  = pos_ext[ctok_pkg::START_W-1:0];

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= 1'b0;
    end else begin
      stage_v <= take;
    end
    if (take) begin
      stage_ch  <= take_ch;
      stage_end <= take_end;
    end
  end

  // Keyword match on the buffered identifier, all nine in parallel
  always_comb begin
    logic hit;
    kw_kind = ctok_pkg::K_IDENT;
    for (int i = ctok_pkg::KW_COUNT - 1; i >= 0; i--) begin
      hit = (token_length == ctok_pkg::LEN_W'(ctok_pkg::KW_LEN[i]));
      for (int j = 0; j < ctok_pkg::KW_MAXLEN; j++) begin
        if ((ctok_pkg::KW_LEN_W'(j) < ctok_pkg::KW_LEN[i]) &&
            (keyword_buffer[j] != ctok_pkg::KW_TEXT[i][8*j +: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kw_kind = ctok_pkg::KIND_W'(i + 1);
      end
    end
  end

  // Token closed by the current byte (the open one, if any)
  always_comb begin
    flush_v         = (mode != ctok_pkg::MODE_IDLE);
    flush_tok       = '0;
    flush_tok.start = token_start;
    flush_tok.len   = token_length;
    case (mode)
      ctok_pkg::MODE_NUM:   flush_tok.kind = ctok_pkg::K_NUMBER;
      ctok_pkg::MODE_IDENT: flush_tok.kind = kw_kind;
      ctok_pkg::MODE_OP: begin
        flush_tok.kind = ctok_pkg::single_op_kind(pending_op);
        flush_tok.len  = ctok_pkg::LEN_W'(1);
      end
      default:              flush_tok.kind = ctok_pkg::K_END;
    endcase
  end

  assign cont = ((mode == ctok_pkg::MODE_NUM) && ctok_pkg::is_digit(stage_ch)) ||
                ((mode == ctok_pkg::MODE_IDENT) && ctok_pkg::is_ident(stage_ch));
  assign pair = (mode == ctok_pkg::MODE_OP) &&
                (stage_ch == ctok_pkg::second_of(pending_op));

  // Next state and emitted tokens
  always_comb begin
    mode_next          = mode;
    pending_op_next    = pending_op;
    token_start_next   = token_start;
    token_length_next  = token_length;
    byte_position_next = byte_position;
    kb_we              = 1'b0;
    kb_idx             = token_length[KB_AW-1:0];
    new_v              = 1'b0;
    new_tok            = '0;
    wr                 = '0;

    if (stage_v) begin
      if (stage_end) begin
        // flush, then END at the marker's position; back to reset state
        new_v              = 1'b1;
        new_tok.kind       = ctok_pkg::K_END;
        new_tok.start      = pos_lo;
        mode_next          = ctok_pkg::MODE_IDLE;
        pending_op_next    = '0;
        token_start_next   = '0;
        token_length_next  = '0;
        byte_position_next = '0;
      end else begin
        byte_position_next = byte_position + POS_WIDTH'(1);
        if (pair) begin
          // two-character operator closes alone
          mode_next = ctok_pkg::MODE_IDLE;
        end else if (cont) begin
          if ((mode == ctok_pkg::MODE_IDENT) &&
              (token_length < ctok_pkg::LEN_W'(MAX_KEYWORD_LEN))) begin
            kb_we = 1'b1;
          end
          if (token_length != '1) begin
            token_length_next = token_length + ctok_pkg::LEN_W'(1);
          end
        end else begin
          mode_next     = ctok_pkg::MODE_IDLE;
          new_tok.start = pos_lo;
          new_tok.len   = ctok_pkg::LEN_W'(1);
          if (ctok_pkg::is_space(stage_ch)) begin
            // skipped
          end else if (ctok_pkg::is_digit(stage_ch)) begin
            mode_next         = ctok_pkg::MODE_NUM;
            token_start_next  = pos_lo;
            token_length_next = ctok_pkg::LEN_W'(1);
          end else if (ctok_pkg::is_alpha(stage_ch) || (stage_ch == "_")) begin
            mode_next         = ctok_pkg::MODE_IDENT;
            token_start_next  = pos_lo;
            token_length_next = ctok_pkg::LEN_W'(1);
            kb_we             = 1'b1;
            kb_idx            = '0;
          end else if (ctok_pkg::holds(stage_ch)) begin
            mode_next         = ctok_pkg::MODE_OP;
            pending_op_next   = stage_ch;
            token_start_next  = pos_lo;
            token_length_next = ctok_pkg::LEN_W'(1);
          end else begin
            new_v        = 1'b1;
            new_tok.kind = ctok_pkg::single_op_kind(stage_ch);
          end
        end
      end

      // Pack the results in order, last flag on the final one
      if (pair && !stage_end) begin
        wr.cnt      = 2'd1;
        wr.t0.kind  = ctok_pkg::single_op_kind(pending_op) + ctok_pkg::KIND_W'(1);
        wr.t0.start = token_start;
        wr.t0.len   = ctok_pkg::LEN_W'(2);
        wr.t0.last  = 1'b1;
      end else if (flush_v && (stage_end || !cont)) begin
        wr.t0      = flush_tok;
        wr.t1      = new_tok;
        wr.t1.last = 1'b1;
        wr.t0.last = !new_v;
        wr.cnt     = new_v ? 2'd2 : 2'd1;
      end else if (new_v) begin
        wr.t0      = new_tok;
        wr.t0.last = 1'b1;
        wr.cnt     = 2'd1;
      end
    end
  end

  // Scanner state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= ctok_pkg::MODE_IDLE;
      pending_op    <= '0;
      token_start   <= '0;
      token_length  <= '0;
      byte_position <= '0;
    end else begin
      mode          <= mode_next;
      pending_op    <= pending_op_next;
      token_start   <= token_start_next;
      token_length  <= token_length_next;
      byte_position <= byte_position_next;
    end
  end

  // Keyword buffer: first bytes of the open identifier
  always_ff @(posedge clk) begin
    if (kb_we) begin
      keyword_buffer[kb_idx] <= stage_ch;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ctok_oq.sv @@
// Output token queue: takes up to two tokens a cycle, hands out one per pop.
// Depends on ctok_pkg.
`default_nettype none

module ctok_oq (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ctok_pkg::tok_pair_t    wr,
  input  wire logic                   pop,
  output ctok_pkg::tok_t              head,
  output logic [ctok_pkg::OQ_CW-1:0]  occ
);

  ctok_pkg::tok_t mem [ctok_pkg::OQ_DEPTH];

  logic [ctok_pkg::OQ_AW-1:0] wr_ptr, rd_ptr;
  logic [ctok_pkg::OQ_AW-1:0] wr_ptr1;

  assign wr_ptr1 = wr_ptr + ctok_pkg::OQ_AW'(1);
  assign head    = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) begin
      mem[wr_ptr] <= wr.t0;
    end
    if (wr.cnt == 2'd2) begin
      mem[wr_ptr1] <= wr.t1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      wr_ptr <= wr_ptr + ctok_pkg::OQ_AW'(wr.cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + ctok_pkg::OQ_AW'(1);
      end
      occ <= occ + ctok_pkg::OQ_CW'(wr.cnt) - ctok_pkg::OQ_CW'(pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/c_subset_tokenizer.sv @@
// Channel   Dir  Width  Contents
// s_*       in   8+1    source byte (tdata), end of source (tlast)
// m_*       out  40+1   token kind/start/length (tdata), last token of a byte (tlast)
//
// One source byte is taken per cycle while s_tready is high. A byte is held
// in the input register; its tokens (zero, one or two) enter an eight-entry
// queue at the next edge and show on m_* once they reach the head of the queue.
// The queue drains one token per cycle while m_tready is high, so bytes that
// each give two tokens fill it until s_tready drops. It drops when the queue,
// counting the byte in the input register, could not take two more tokens.
// Synchronous reset returns the scanner to offset 0 and empties the queue.
// Top level of the C subset tokenizer. Depends on ctok_pkg, ctok_lex, ctok_oq.
`default_nettype none

module c_subset_tokenizer #(
  parameter int POS_WIDTH       = ctok_pkg::POS_WIDTH_DEF,
  parameter int MAX_KEYWORD_LEN = ctok_pkg::MAX_KW_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] ch
  input  wire logic        s_tlast,   // is_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [5:0] token_kind, [29:6] start_res, [37:30] length
  output logic             m_tlast    // last
);

  logic                        take, pop, busy;
  logic [ctok_pkg::OQ_CW:0]    room_need;
  logic [ctok_pkg::OQ_CW-1:0]  occ;
  ctok_pkg::tok_pair_t         wr;
  ctok_pkg::tok_t              head;

  // Space for the byte in flight plus this one, two tokens each
  assign room_need = {1'b0, occ} + (busy ? (ctok_pkg::OQ_CW + 1)'(2) : '0);
  assign s_tready  = (room_need <= (ctok_pkg::OQ_CW + 1)'(ctok_pkg::OQ_DEPTH - 2));
  assign take      = s_tvalid && s_tready;

  ctok_lex #(
    .POS_WIDTH       (POS_WIDTH),
    .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
  ) u_lex (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .take_ch  (s_tdata),
    .take_end (s_tlast),
    .busy     (busy),
    .wr       (wr)
  );

  ctok_oq u_oq (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .pop  (pop),
    .head (head),
    .occ  (occ)
  );

  // Output side
  assign m_tvalid = (occ != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = {2'b00, head.len, head.start, head.kind};
  assign m_tlast  = head.last;

  // Queue never fills beyond its depth
  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= ctok_pkg::OQ_CW'(ctok_pkg::OQ_DEPTH))
    else $error("output queue overflow");

  // End of source always yields at least the END token
  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    take && s_tlast |=> wr.cnt != 2'd0)
    else $error("end of source produced no token");

  // Exactly the final token of a byte carries last
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    wr.cnt != 2'd0 |-> (wr.cnt == 2'd1 && wr.t0.last) ||
                       (wr.cnt == 2'd2 && wr.t1.last && !wr.t0.last))
    else $error("last flag misplaced");

endmodule

`default_nettype wire
